// ----- src/lpht_pkg.sv -----
// Shared types, constants and codes for the linear-probe hash table.
package lpht_pkg;

    localparam int TABLE_SLOTS_DEF = 26;
    localparam int KEY_CHARS_DEF   = 8;

    localparam int KEY_W    = 64;
    localparam int VALUE_W  = 34;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 5;

    localparam logic OP_SEARCH = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic               opcode;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] entry_value;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot_index;
        logic [VALUE_W-1:0]  found_value;
    } rsp_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic done;
    } sts_t;

endpackage

// ----- src/lpht_dp.sv -----
// Datapath: key and value memories, valid bits, probe pointer and result register.
module lpht_dp #(
    parameter int TABLE_SLOTS = lpht_pkg::TABLE_SLOTS_DEF,
    parameter int KEY_CHARS   = lpht_pkg::KEY_CHARS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  lpht_pkg::req_t req,
    input  lpht_pkg::cmd_t cmd,
    output lpht_pkg::sts_t sts,
    output lpht_pkg::rsp_t rsp
);

    localparam int IDX_W = $clog2(TABLE_SLOTS);
    localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
    localparam logic [lpht_pkg::KEY_W-1:0] KEY_MASK =
        (KEY_CHARS >= 8) ? {lpht_pkg::KEY_W{1'b1}}
                         : ((64'd1 << (8 * KEY_CHARS)) - 64'd1);
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_SLOTS - 1);
    localparam logic [CNT_W-1:0] SLOT_COUNT = CNT_W'(TABLE_SLOTS);

    logic [lpht_pkg::KEY_W-1:0]   key_mem [TABLE_SLOTS];
    logic [lpht_pkg::VALUE_W-1:0] val_mem [TABLE_SLOTS];
    logic [TABLE_SLOTS-1:0]       used_reg;

    logic [IDX_W-1:0] home_tab [256];

    logic                         op_reg;
    logic [lpht_pkg::KEY_W-1:0]   key_reg;
    logic [lpht_pkg::VALUE_W-1:0] val_reg;
    logic [IDX_W-1:0]             ptr_reg;
    logic [CNT_W-1:0]             issue_cnt_reg;
    logic [CNT_W-1:0]             cmp_cnt_reg;
    logic                         stage_vld_reg;
    logic                         stage_used_reg;
    logic [IDX_W-1:0]             stage_addr_reg;
    logic [lpht_pkg::KEY_W-1:0]   rd_key_reg;
    logic [lpht_pkg::VALUE_W-1:0] rd_val_reg;
    logic                         hit_reg;
    logic [IDX_W-1:0]             hit_slot_reg;
    logic [lpht_pkg::VALUE_W-1:0] hit_val_reg;
    logic                         free_found_reg;
    logic [IDX_W-1:0]             free_slot_reg;
    lpht_pkg::rsp_t               rsp_reg;
    lpht_pkg::rsp_t               rsp_next;

    logic issue;
    logic match;
    logic do_write;
    logic [IDX_W-1:0] ptr_adv;

    // Home slot of every possible first character, fixed at elaboration.
    for (genvar g = 0; g < 256; g++) begin : g_home
        assign home_tab[g] = IDX_W'(g % TABLE_SLOTS);
    end

    assign issue    = cmd.scan && (issue_cnt_reg < SLOT_COUNT);
    assign match    = stage_vld_reg && stage_used_reg && (rd_key_reg == key_reg);
    assign ptr_adv  = (ptr_reg == LAST_SLOT) ? '0 : ptr_reg + 1'b1;
    assign do_write = cmd.commit && (op_reg == lpht_pkg::OP_INSERT) && !hit_reg
                      && free_found_reg;

    assign sts.hit  = match;
    assign sts.done = (cmp_cnt_reg == SLOT_COUNT);

    // Payload registers, memories and read data.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= req.opcode;
            key_reg <= req.key & KEY_MASK;
            val_reg <= req.entry_value;
        end
        if (issue)
        begin
            rd_key_reg     <= key_mem[ptr_reg];
            rd_val_reg     <= val_mem[ptr_reg];
            stage_addr_reg <= ptr_reg;
            stage_used_reg <= used_reg[ptr_reg];
        end
        if (do_write)
        begin
            key_mem[free_slot_reg] <= key_reg;
            val_mem[free_slot_reg] <= val_reg;
        end
        if (match && !hit_reg)
        begin
            hit_slot_reg <= stage_addr_reg;
            hit_val_reg  <= rd_val_reg;
        end
        if (issue && !used_reg[ptr_reg] && !free_found_reg)
        begin
            free_slot_reg <= ptr_reg;
        end
        if (cmd.commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // Probe control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg       <= '0;
            ptr_reg        <= '0;
            issue_cnt_reg  <= '0;
            cmp_cnt_reg    <= '0;
            stage_vld_reg  <= 1'b0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            ptr_reg        <= home_tab[req.key[7:0]];
            issue_cnt_reg  <= '0;
            cmp_cnt_reg    <= '0;
            stage_vld_reg  <= 1'b0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            if (cmd.scan)
            begin
                stage_vld_reg <= issue;
                if (stage_vld_reg)
                begin
                    cmp_cnt_reg <= cmp_cnt_reg + 1'b1;
                end
                if (match)
                begin
                    hit_reg <= 1'b1;
                end
            end
            if (issue)
            begin
                ptr_reg       <= ptr_adv;
                issue_cnt_reg <= issue_cnt_reg + 1'b1;
                if (!used_reg[ptr_reg])
                begin
                    free_found_reg <= 1'b1;
                end
            end
            if (do_write)
            begin
                used_reg[free_slot_reg] <= 1'b1;
            end
        end
    end

    // Result of the finished probe.
    always_comb
    begin
        rsp_next.status      = lpht_pkg::ST_NOT_FOUND;
        rsp_next.slot_index  = '0;
        rsp_next.found_value = '0;
        if (hit_reg)
        begin
            rsp_next.status      = (op_reg == lpht_pkg::OP_INSERT) ? lpht_pkg::ST_DUPLICATE
                                                                   : lpht_pkg::ST_OK;
            rsp_next.slot_index  = lpht_pkg::SLOT_W'(hit_slot_reg);
            rsp_next.found_value = hit_val_reg;
        end
        else if (op_reg == lpht_pkg::OP_INSERT)
        begin
            if (free_found_reg)
            begin
                rsp_next.status     = lpht_pkg::ST_OK;
                rsp_next.slot_index = lpht_pkg::SLOT_W'(free_slot_reg);
            end
            else
            begin
                rsp_next.status = lpht_pkg::ST_FULL;
            end
        end
    end

    assign rsp = rsp_reg;

`ifndef SYNTH
    a_hit_in_used_slot: assert property (@(posedge clk) disable iff (!rst_n)
        hit_reg |-> used_reg[hit_slot_reg])
        else $error("hit recorded on an unused slot");

    a_cmp_behind_issue: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_cnt_reg <= issue_cnt_reg)
        else $error("compare count ran ahead of issued reads");

    a_write_needs_free: assert property (@(posedge clk) disable iff (!rst_n)
        do_write |-> !used_reg[free_slot_reg])
        else $error("insert would overwrite a used slot");
`endif

endmodule

// ----- src/lpht_ctrl.sv -----
// Controller: sequences load, probe scan and result commit for one transaction.
module lpht_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    input  lpht_pkg::sts_t sts,
    output lpht_pkg::cmd_t cmd
);

    lpht_pkg::state_t state_reg;
    lpht_pkg::state_t state_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    logic             out_free;

    assign out_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lpht_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = lpht_pkg::S_SCAN;
                end
            end
            lpht_pkg::S_SCAN:
            begin
                if (sts.hit || sts.done)
                begin
                    state_next = lpht_pkg::S_FINISH;
                end
            end
            lpht_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = lpht_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = lpht_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.load       = 1'b0;
        cmd.scan       = 1'b0;
        cmd.commit     = 1'b0;
        req_stall      = 1'b1;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        case (state_reg)
            lpht_pkg::S_IDLE:
            begin
                req_stall = 1'b0;
                cmd.load  = req_valid;
            end
            lpht_pkg::S_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            lpht_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.commit     = 1'b1;
                    rsp_valid_next = 1'b1;
                end
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lpht_pkg::S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

`ifndef SYNTH
    a_finish_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lpht_pkg::S_FINISH && out_free)
        |=> (state_reg == lpht_pkg::S_IDLE && rsp_valid_reg))
        else $error("finished transaction not delivered");

    a_scan_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lpht_pkg::S_SCAN) |=> (state_reg != lpht_pkg::S_IDLE))
        else $error("scan returned to idle without a result");

    a_rsp_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) == lpht_pkg::S_FINISH))
        else $error("result raised outside the finish step");
`endif

endmodule

// ----- src/linear_probe_hash_table_core.sv -----
// Top level of the linear-probe hash table: controller plus datapath.
// A hit ends the probe as soon as it is found; a miss or a fresh insert reads all slots
// before it answers, and the answer waits while the output register is stalled.
// Throughput: one transaction at a time; the next is taken in idle once the result
// is registered. The probe reads one slot per cycle over the key and value memories.
// Reset empties every slot.
module linear_probe_hash_table_core #(
    parameter int TABLE_SLOTS = lpht_pkg::TABLE_SLOTS_DEF,
    parameter int KEY_CHARS   = lpht_pkg::KEY_CHARS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  lpht_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output lpht_pkg::rsp_t rsp
);

    // Command and status between the controller and the datapath.
    lpht_pkg::cmd_t cmd;
    lpht_pkg::sts_t sts;

    // The controller takes a request only in idle, walks the probe sequence,
    // and commits the result once the output register is free to take it.
    lpht_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // The datapath reads one slot per cycle starting at the home slot,
    // compares the read key in the next cycle, tracks the first free slot on the way,
    // and writes the new entry on commit of a successful insert.
    lpht_dp #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .KEY_CHARS   (KEY_CHARS)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .sts   (sts),
        .rsp   (rsp)
    );

endmodule

// ----- tb/lpht_checker.sv -----
// Response predictor and scoreboard for the linear-probe hash table.
`timescale 1ns / 1ps
module lpht_checker #(
    parameter int TABLE_SLOTS = lpht_pkg::TABLE_SLOTS_DEF,
    parameter int KEY_CHARS   = lpht_pkg::KEY_CHARS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic           req_stall,
    input  lpht_pkg::req_t req,
    input  logic           rsp_valid,
    input  logic           rsp_stall,
    input  lpht_pkg::rsp_t rsp,
    output int             fail_count,
    output int             outstanding,
    output int             ok_total,
    output int             miss_total,
    output int             dup_total,
    output int             full_total
);

    localparam logic [lpht_pkg::KEY_W-1:0] KEY_MASK =
        (KEY_CHARS >= 8) ? {lpht_pkg::KEY_W{1'b1}}
                         : ((64'd1 << (8 * KEY_CHARS)) - 64'd1);

    logic [lpht_pkg::KEY_W-1:0]   stored_key   [TABLE_SLOTS];
    logic [lpht_pkg::VALUE_W-1:0] stored_value [TABLE_SLOTS];
    logic                         slot_taken   [TABLE_SLOTS];

    lpht_pkg::rsp_t pending_rsps[$];
    lpht_pkg::rsp_t want;
    int   errors;
    int   n_ok;
    int   n_miss;
    int   n_dup;
    int   n_full;

    // Walk the probe path once: note the first matching slot and the first free one,
    // then update the table the same way the block should.
    function automatic lpht_pkg::rsp_t resolve_request(input lpht_pkg::req_t item);
        lpht_pkg::rsp_t             res;
        logic [lpht_pkg::KEY_W-1:0] k;
        int                         home;
        int                         hit;
        int                         vacant;
        int                         s;
        int                         i;
        res    = '0;
        k      = item.key & KEY_MASK;
        home   = int'(k[7:0]) % TABLE_SLOTS;
        hit    = -1;
        vacant = -1;
        for (i = 0; i < TABLE_SLOTS; i++)
        begin
            s = (home + i) % TABLE_SLOTS;
            if (hit < 0 && slot_taken[s] && stored_key[s] == k)
                hit = s;
            if (vacant < 0 && !slot_taken[s])
                vacant = s;
        end
        if (hit >= 0)
        begin
            res.status      = (item.opcode == lpht_pkg::OP_SEARCH) ? lpht_pkg::ST_OK
                                                                   : lpht_pkg::ST_DUPLICATE;
            res.slot_index  = hit[lpht_pkg::SLOT_W-1:0];
            res.found_value = stored_value[hit];
        end
        else if (item.opcode == lpht_pkg::OP_SEARCH)
            res.status = lpht_pkg::ST_NOT_FOUND;
        else if (vacant >= 0)
        begin
            stored_key[vacant]   = k;
            stored_value[vacant] = item.entry_value;
            slot_taken[vacant]   = 1'b1;
            res.status           = lpht_pkg::ST_OK;
            res.slot_index       = vacant[lpht_pkg::SLOT_W-1:0];
        end
        else
            res.status = lpht_pkg::ST_FULL;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < TABLE_SLOTS; j++)
                slot_taken[j] = 1'b0;
            pending_rsps.delete();
            errors = 0;
            n_ok   = 0;
            n_miss = 0;
            n_dup  = 0;
            n_full = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (pending_rsps.size() == 0)
                begin
                    $error("unexpected response: status %0d, slot_index %0d, found_value %0d",
                           rsp.status, rsp.slot_index, rsp.found_value);
                    errors++;
                end
                else
                begin
                    want = pending_rsps.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, rsp.status);
                        errors++;
                    end
                    if (rsp.slot_index !== want.slot_index)
                    begin
                        $error("slot_index: expected %0d, actual %0d",
                               want.slot_index, rsp.slot_index);
                        errors++;
                    end
                    if (rsp.found_value !== want.found_value)
                    begin
                        $error("found_value: expected %0d, actual %0d",
                               want.found_value, rsp.found_value);
                        errors++;
                    end
                    case (want.status)
                        lpht_pkg::ST_OK:        n_ok++;
                        lpht_pkg::ST_NOT_FOUND: n_miss++;
                        lpht_pkg::ST_DUPLICATE: n_dup++;
                        default:                n_full++;
                    endcase
                end
            end
            if (req_valid && !req_stall)
                pending_rsps.push_back(resolve_request(req));
        end
        fail_count  <= errors;
        outstanding <= pending_rsps.size();
        ok_total    <= n_ok;
        miss_total  <= n_miss;
        dup_total   <= n_dup;
        full_total  <= n_full;
    end

endmodule

// ----- tb/linear_probe_hash_table_core_tb.sv -----
// Top of the linear-probe hash table testbench: stimulus, stall pattern and verdict.
`timescale 1ns / 1ps
module linear_probe_hash_table_core_tb;

    localparam int RANDOM_ITEMS = 900;
    localparam int DRAIN_CYCLES = 40;   // margin beyond the longest probe

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_SPARSE,
        STALL_RUNS
    } stall_mode_t;

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           req_valid = 1'b0;
    logic           req_stall;
    lpht_pkg::req_t req       = '0;
    logic           rsp_valid;
    logic           rsp_stall = 1'b0;
    lpht_pkg::rsp_t rsp;

    int fail_count;
    int outstanding;
    int ok_total;
    int miss_total;
    int dup_total;
    int full_total;

    // Sender bookkeeping: transactions left in the current burst, keys sent for insert.
    int                         burst_left = 0;
    int                         sent_total = 0;
    logic [lpht_pkg::KEY_W-1:0] known_keys[$];

    // Receiver stall pattern state.
    stall_mode_t stall_mode      = STALL_NONE;
    int          stall_mode_left = 0;
    int          stall_run_left  = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    linear_probe_hash_table_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    lpht_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .fail_count  (fail_count),
        .outstanding (outstanding),
        .ok_total    (ok_total),
        .miss_total  (miss_total),
        .dup_total   (dup_total),
        .full_total  (full_total)
    );

    // Random key whose first character often lands on a crowded home slot
    // (0, 13 or 25), so probe chains grow long and wrap past the last slot.
    function automatic logic [lpht_pkg::KEY_W-1:0] clustered_key();
        logic [lpht_pkg::KEY_W-1:0] k;
        int                         first_char;
        k = {$urandom, $urandom};
        if ($urandom_range(0, 1) == 0)
        begin
            case ($urandom_range(0, 2))
                0:       first_char = 0;
                1:       first_char = 13;
                default: first_char = 25;
            endcase
            first_char = first_char + 26 * $urandom_range(0, 8);
            k[7:0]     = first_char[7:0];
        end
        return k;
    endfunction

    // Reuse a key already sent for insert; fall back to a fresh one early on.
    function automatic logic [lpht_pkg::KEY_W-1:0] pick_known();
        if (known_keys.size() == 0)
            return clustered_key();
        return known_keys[$urandom_range(0, known_keys.size() - 1)];
    endfunction

    // Full 34-bit range, so values above the decimal limit show up too.
    function automatic logic [lpht_pkg::VALUE_W-1:0] random_value();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[lpht_pkg::VALUE_W-1:0];
    endfunction

    // Present one transaction and hold it until accepted. Valid stays high across a
    // burst; at the end of a burst drop valid for a random gap, then pick a new burst.
    task automatic issue(input logic op, input logic [lpht_pkg::KEY_W-1:0] k,
                         input logic [lpht_pkg::VALUE_W-1:0] v);
        lpht_pkg::req_t item;
        item.opcode      = op;
        item.key         = k;
        item.entry_value = v;
        req       <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        sent_total++;
        if (op == lpht_pkg::OP_INSERT)
            known_keys.push_back(k);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 10))
                @(posedge clk);
            burst_left = $urandom_range(0, 24);
        end
    endtask

    // Receiver: switch at random among no stall, scattered stalls and long stall runs,
    // so stalls land on every phase of the probe.
    always @(posedge clk)
    begin
        if (stall_mode_left == 0)
        begin
            stall_mode      <= stall_mode_t'($urandom_range(0, 2));
            stall_mode_left <= $urandom_range(50, 300);
        end
        else
            stall_mode_left <= stall_mode_left - 1;
        case (stall_mode)
            STALL_NONE:
                rsp_stall <= 1'b0;
            STALL_SPARSE:
                rsp_stall <= ($urandom_range(0, 99) < 40);
            default:
            begin
                if (stall_run_left == 0)
                begin
                    rsp_stall      <= ~rsp_stall;
                    stall_run_left <= $urandom_range(1, 40);
                end
                else
                    stall_run_left <= stall_run_left - 1;
            end
        endcase
    end

    initial
    begin
        int                         pick;
        logic [lpht_pkg::KEY_W-1:0] k;
        int                         flip;

        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: empty-table miss, zero key, all-ones key, value extremes,
        // collisions on a shared home slot, wrap from the last slot, high first byte.
        issue(lpht_pkg::OP_SEARCH, 64'h0, 34'h0);                   // miss on empty table
        issue(lpht_pkg::OP_INSERT, 64'h0, {lpht_pkg::VALUE_W{1'b1}}); // zero key, over range
        issue(lpht_pkg::OP_INSERT, 64'h0, 34'd5);                   // duplicate, no change
        issue(lpht_pkg::OP_SEARCH, 64'h0, 34'h0);
        issue(lpht_pkg::OP_INSERT, {lpht_pkg::KEY_W{1'b1}}, 34'h0); // home slot 21
        issue(lpht_pkg::OP_SEARCH, {lpht_pkg::KEY_W{1'b1}}, 34'h0);
        issue(lpht_pkg::OP_INSERT, 64'h0000_0045_4349_4C41, 34'd9999999999); // "ALICE", 13
        issue(lpht_pkg::OP_INSERT, 64'h0000_0000_0059_4D41, 34'd1234567890); // "AMY" to 14
        issue(lpht_pkg::OP_INSERT, 64'h0000_0000_0000_000D, 34'd42); // home 13, lands on 15
        issue(lpht_pkg::OP_SEARCH, 64'h0000_0000_0059_4D41, 34'h0);
        issue(lpht_pkg::OP_SEARCH, 64'h0000_0000_0000_0041, 34'h0); // same home, absent
        issue(lpht_pkg::OP_INSERT, 64'h5A5A_0000_0000_0019, 34'd7);  // last slot
        issue(lpht_pkg::OP_INSERT, 64'h0000_0000_0000_3333, 34'd8);  // home 25, wraps to 1
        issue(lpht_pkg::OP_SEARCH, 64'h0000_0000_0000_3333, 34'h0);
        issue(lpht_pkg::OP_INSERT, 64'h0000_0000_0000_00FF, 34'd9);  // first byte 255
        issue(lpht_pkg::OP_INSERT, 64'h0000_0000_0000_0080, 34'd10); // first byte 128
        issue(lpht_pkg::OP_INSERT, 64'h0000_0000_0000_0100, 34'd11); // home 0, past two taken
        issue(lpht_pkg::OP_INSERT, 64'h0000_0045_4349_4C41, 34'd1);  // duplicate of "ALICE"
        issue(lpht_pkg::OP_SEARCH, 64'h0000_0000_0000_0100, 34'h0);
        issue(lpht_pkg::OP_SEARCH, 64'h8000_0000_0000_0000, 34'h0); // zero first byte, absent

        // Random part: few new keys, so the table stays partly full for a few hundred
        // transactions before it fills and further inserts come back as full.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 6)
                issue(lpht_pkg::OP_INSERT, clustered_key(), random_value());
            else if (pick < 20)
                issue(lpht_pkg::OP_INSERT, pick_known(), random_value());
            else if (pick < 60)
                issue(lpht_pkg::OP_SEARCH, pick_known(), random_value());
            else if (pick < 85)
                issue(lpht_pkg::OP_SEARCH, clustered_key(), random_value());
            else
            begin
                // Near miss: a stored key with one bit flipped.
                k       = pick_known();
                flip    = $urandom_range(0, lpht_pkg::KEY_W - 1);
                k[flip] = ~k[flip];
                issue(lpht_pkg::OP_SEARCH, k, random_value());
            end
        end
        req_valid <= 1'b0;

        // Drain: let the last acceptance reach the checker, then wait out the queue.
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("Sent %0d transactions: %0d found or placed, %0d not found,",
                 sent_total, ok_total, miss_total);
        $display("%0d duplicates, %0d refused on a full table", dup_total, full_total);
        if (fail_count == 0)
            $display("linear_probe_hash_table_core regression: pass");
        else
            $display("linear_probe_hash_table_core regression: fail");
        $finish;
    end

    // Hang guard, far beyond the slowest legal run.
    initial
    begin
        #10_000_000;
        $display("linear_probe_hash_table_core regression: fail");
        $finish;
    end

endmodule
